>>> hdl/rfg_pkg.sv
// rainbow frame generator package: payload types, register codes and palette logic
// no dependencies; used by the core and the testbench
`default_nettype none

package rfg_pkg;

    // default array size
    localparam int ROWS_DEF = 4;
    localparam int COLS_DEF = 16;

    // register indexes on the configuration port
    localparam int          CFG_IDX_W            = 2;
    localparam int          CFG_DATA_W           = 16;
    localparam logic [1:0]  REG_FRAME_DELAY      = 2'd0;
    localparam logic [1:0]  REG_PALETTE          = 2'd1;
    localparam logic [1:0]  REG_PHASE_DECREMENT  = 2'd2;
    localparam logic [1:0]  REG_PHASE_SUBTRACT   = 2'd3;

    // register reset values
    localparam logic [15:0] FRAME_DELAY_RST = 16'd15;

    // palette codes (the unused code falls back to the classic wheel)
    localparam logic [1:0]  PAL_CLASSIC   = 2'd0;
    localparam logic [1:0]  PAL_FADE_OUT  = 2'd1;
    localparam logic [1:0]  PAL_FADE_IN   = 2'd2;

    // wheel segment thresholds
    localparam logic [7:0]  SEG_ONE = 8'd85;
    localparam logic [7:0]  SEG_TWO = 8'd170;

    // tick payload
    typedef struct packed {
        logic [31:0] now_ms;
        logic        transfer_idle;
    } t_tick;

    // led result payload
    typedef struct packed {
        logic [1:0] row;
        logic [3:0] column;
        logic [7:0] byte_low;
        logic [7:0] byte_mid;
        logic [7:0] byte_high;
        logic       last;
    } t_led;

    // packed colour word for a wheel position; components are not clipped,
    // so anything above 255 spills into the next field up, or is cut off for red
    function automatic logic [23:0] colour_word(input logic [1:0] pal, input logic [7:0] pos);
        logic [7:0]  q;
        logic [9:0]  q3;
        logic [9:0]  r;
        logic [9:0]  g;
        logic [9:0]  b;
        logic [23:0] word;
        r = '0;
        g = '0;
        b = '0;
        if (pal == PAL_FADE_OUT || pal == PAL_FADE_IN) begin
            // snappy fades
            q = (pal == PAL_FADE_OUT) ? pos : 8'(8'd255 - pos);
            if (q < SEG_ONE) begin
                q3 = {2'b00, q} * 10'd3;
                r  = q3;
                b  = q3;
            end else if (q < SEG_TWO) begin
                q  = 8'(q + SEG_ONE);
                q3 = {2'b00, q} * 10'd3;
                g  = q3;
                b  = q3;
            end else begin
                q  = 8'(q + SEG_TWO);
                q3 = {2'b00, q} * 10'd3;
                r  = q3;
                g  = q3;
            end
        end else begin
            // classic wheel
            q = 8'(8'd255 - pos);
            if (q < SEG_ONE) begin
                q3 = {2'b00, q} * 10'd3;
                r  = 10'd255 - q3;
                b  = q3;
            end else if (q < SEG_TWO) begin
                q  = 8'(q - SEG_ONE);
                q3 = {2'b00, q} * 10'd3;
                g  = q3;
                b  = 10'd255 - q3;
            end else begin
                q  = 8'(q - SEG_TWO);
                q3 = {2'b00, q} * 10'd3;
                r  = q3;
                g  = 10'd255 - q3;
            end
        end
        word = ({14'd0, r} << 16) | ({14'd0, g} << 8) | {14'd0, b};
        return word;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rfg_stream_if.sv
// valid/ready stream channel carrying one payload per transfer
// payload type is a parameter; types come from rfg_pkg
`default_nettype none

interface rfg_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/rainbow_frame_generator_core.sv
// rainbow frame generator core: tick in, one colour transfer per led out
// depends on rfg_pkg and rfg_stream_if
`default_nettype none

// Each accepted tick steps the shared phase by one. When the tick reports the
// link idle and more than frame_delay ms have passed since the last frame, the
// core emits ROWS*COLS led transfers, row by row, each rows repeating the same
// colours. Every led needs col*256/frame_delay, worked out by one restoring
// divider a bit per cycle; the colour is then looked up and registered in the
// load state, which waits while the output register holds an led not yet taken.
// The tick input is not ready while a frame is in progress; the last led may
// still wait in the output register when the next tick is taken.
module rainbow_frame_generator_core #(
    parameter int ROWS = rfg_pkg::ROWS_DEF,
    parameter int COLS = rfg_pkg::COLS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rfg_stream_if.sink                         i_tick,
    rfg_stream_if.source                       o_led,
    input  wire logic                          i_cfg_we,
    input  wire logic [rfg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rfg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ROWW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COLW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int DVDW = COLW + 8;
    localparam int CNTW = $clog2(DVDW);
    localparam logic [ROWW-1:0] ROW_LAST = ROWW'(ROWS - 1);
    localparam logic [COLW-1:0] COL_LAST = COLW'(COLS - 1);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DVDW - 1);

    // sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [15:0]      r_frame_delay;
    logic [1:0]       r_palette;
    logic             r_phase_decrement;
    logic             r_phase_subtract;
    logic [7:0]       r_phase, n_phase;
    logic [31:0]      r_last_ms, n_last_ms;
    logic [ROWW-1:0]  r_row, n_row;
    logic [COLW-1:0]  r_col, n_col;
    logic [DVDW-1:0]  r_dvd, n_dvd;
    logic [15:0]      r_rem, n_rem;
    logic [7:0]       r_quo, n_quo;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    rfg_pkg::t_led    r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic        tick_fire;
    logic [15:0] divisor;
    logic [16:0] rem_shift;
    logic        quo_bit;
    logic [7:0]  pos;
    logic [23:0] word;
    logic        led_last;
    logic        out_free;
    logic [31:0] elapsed;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_delay     <= rfg_pkg::FRAME_DELAY_RST;
            r_palette         <= rfg_pkg::PAL_CLASSIC;
            r_phase_decrement <= 1'b0;
            r_phase_subtract  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rfg_pkg::REG_FRAME_DELAY:     r_frame_delay     <= i_cfg_data;
                rfg_pkg::REG_PALETTE:         r_palette         <= i_cfg_data[1:0];
                rfg_pkg::REG_PHASE_DECREMENT: r_phase_decrement <= i_cfg_data[0];
                rfg_pkg::REG_PHASE_SUBTRACT:  r_phase_subtract  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign i_tick.ready = (r_state == ST_IDLE);
    assign tick_fire    = i_tick.valid && i_tick.ready;
    assign divisor      = (r_frame_delay == 16'd0) ? 16'd1 : r_frame_delay;
    assign elapsed      = i_tick.payload.now_ms - r_last_ms;

    // shared divider step
    assign rem_shift = {r_rem, r_dvd[DVDW-1]};
    assign quo_bit   = (rem_shift >= {1'b0, divisor});

    // wheel position and colour lookup
    assign pos      = r_phase_subtract ? 8'(r_quo - r_phase) : 8'(r_quo + r_phase);
    assign word     = rfg_pkg::colour_word(r_palette, pos);
    assign led_last = (r_row == ROW_LAST) && (r_col == COL_LAST);
    assign out_free = !r_out_valid || o_led.ready;

    assign o_led.valid   = r_out_valid;
    assign o_led.payload = r_out;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_last_ms   = r_last_ms;
        n_row       = r_row;
        n_col       = r_col;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // output register drains on a transfer
        if (r_out_valid && o_led.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (tick_fire) begin
                    n_phase = r_phase_decrement ? 8'(r_phase - 8'd1) : 8'(r_phase + 8'd1);
                    if (i_tick.payload.transfer_idle && (elapsed > {16'd0, r_frame_delay})) begin
                        n_last_ms = i_tick.payload.now_ms;
                        n_row     = '0;
                        n_col     = '0;
                        n_dvd     = '0;
                        n_rem     = '0;
                        n_cnt     = '0;
                        n_state   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_rem = quo_bit ? 16'(rem_shift - {1'b0, divisor}) : rem_shift[15:0];
                n_quo = {r_quo[6:0], quo_bit};
                n_dvd = r_dvd << 1;
                n_cnt = CNTW'(r_cnt + 1'b1);
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    n_out.row       = 2'(r_row);
                    n_out.column    = 4'(r_col);
                    n_out.byte_low  = word[7:0];
                    n_out.byte_mid  = word[15:8];
                    n_out.byte_high = word[23:16];
                    n_out.last      = led_last;
                    n_out_valid     = 1'b1;
                    if (led_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        if (r_col == COL_LAST) begin
                            n_col = '0;
                            n_row = ROWW'(r_row + 1'b1);
                            n_dvd = '0;
                        end else begin
                            n_col = COLW'(r_col + 1'b1);
                            n_dvd = {COLW'(r_col + 1'b1), 8'd0};
                        end
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_state = ST_DIV;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_last_ms   <= '0;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_last_ms   <= n_last_ms;
            r_out_valid <= n_out_valid;
            r_row       <= n_row;
            r_col       <= n_col;
            r_cnt       <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_out <= n_out;
    end

endmodule

`default_nettype wire

>>> tb/sv/rainbow_frame_generator_core_test.sv
`timescale 1ns / 1ps
// self-checking bench for the rainbow frame generator core: ticks in, led colours out
// a scripted opening then random ticks, all checked against an in-bench colour predictor
// depends on rfg_pkg, rfg_stream_if and rainbow_frame_generator_core

module rainbow_frame_generator_core_test;

    localparam int          LED_ROWS        = rfg_pkg::ROWS_DEF;
    localparam int          LED_COLS        = rfg_pkg::COLS_DEF;
    localparam int          SCRIPT_ROWS     = 32;
    localparam int          RANDOM_PHASES   = 8;
    localparam int          TICKS_PER_PHASE = 60;
    localparam int          IDLE_CYCLES     = 16;
    localparam int          SHOWN_FAULTS    = 40;
    localparam longint      LIMIT_NS        = 64'd10_000_000;
    // spare palette code, expected to behave as the classic wheel
    localparam logic [1:0]  PAL_UNUSED      = 2'd3;

    typedef enum logic [1:0] {STEP_TICK, STEP_CFG} t_step_kind;
    typedef enum logic [1:0] {FRAME_ANY, FRAME_NONE, FRAME_EMIT} t_frame_hint;

    typedef struct {
        t_step_kind  kind;
        logic [1:0]  idx;
        logic [31:0] value;
        logic        idle;
        t_frame_hint hint;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [rfg_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rfg_pkg::CFG_DATA_W-1:0] i_cfg_data;

    rfg_stream_if #(.t_payload(rfg_pkg::t_tick)) tick_if ();
    rfg_stream_if #(.t_payload(rfg_pkg::t_led))  led_if ();

    rainbow_frame_generator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (tick_if),
        .o_led      (led_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // mirror of the block state and registers
    logic [7:0]  wheel_phase;
    logic [31:0] last_frame_ms;
    logic [15:0] cfg_delay;
    logic [1:0]  cfg_palette;
    logic        cfg_step_down;
    logic        cfg_reverse;

    rfg_pkg::t_led pending_leds[$];
    int unsigned fault_count;
    int unsigned tick_count;
    int unsigned frame_count;
    int unsigned leds_checked;
    int unsigned settings_written;
    int unsigned burst_left;
    int unsigned sink_hold;

    // opening script: time window edges, wrap, palettes, phase direction, delay extremes
    t_script_row script [SCRIPT_ROWS] = '{
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd0,         1'b1, FRAME_NONE},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd15,        1'b1, FRAME_NONE},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd16,        1'b0, FRAME_NONE},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd16,        1'b1, FRAME_EMIT},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'hFFFF_FFFF, 1'b1, FRAME_EMIT},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd14,        1'b1, FRAME_NONE},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd15,        1'b1, FRAME_EMIT},
        '{STEP_CFG,  rfg_pkg::REG_PALETTE,  32'(rfg_pkg::PAL_FADE_OUT), 1'b0, FRAME_ANY},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd100,       1'b1, FRAME_EMIT},
        '{STEP_CFG,  rfg_pkg::REG_PALETTE,  32'(rfg_pkg::PAL_FADE_IN),  1'b0, FRAME_ANY},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd200,       1'b1, FRAME_EMIT},
        '{STEP_CFG,  rfg_pkg::REG_PALETTE,         32'(PAL_UNUSED), 1'b0, FRAME_ANY},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd300,       1'b1, FRAME_EMIT},
        '{STEP_CFG,  rfg_pkg::REG_PHASE_DECREMENT, 32'd1,         1'b0, FRAME_ANY},
        '{STEP_CFG,  rfg_pkg::REG_PHASE_SUBTRACT,  32'd1,         1'b0, FRAME_ANY},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd400,       1'b1, FRAME_EMIT},
        '{STEP_CFG,  rfg_pkg::REG_FRAME_DELAY,     32'd0,         1'b0, FRAME_ANY},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd400,       1'b1, FRAME_NONE},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd401,       1'b1, FRAME_EMIT},
        '{STEP_CFG,  rfg_pkg::REG_FRAME_DELAY,     32'd1,         1'b0, FRAME_ANY},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd402,       1'b1, FRAME_NONE},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd403,       1'b1, FRAME_EMIT},
        '{STEP_CFG,  rfg_pkg::REG_FRAME_DELAY,     32'd65535,     1'b0, FRAME_ANY},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd65938,     1'b1, FRAME_NONE},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'd65939,     1'b1, FRAME_EMIT},
        '{STEP_CFG,  rfg_pkg::REG_FRAME_DELAY,     32'd15,        1'b0, FRAME_ANY},
        '{STEP_CFG,  rfg_pkg::REG_PALETTE,  32'(rfg_pkg::PAL_CLASSIC),  1'b0, FRAME_ANY},
        '{STEP_CFG,  rfg_pkg::REG_PHASE_DECREMENT, 32'd0,         1'b0, FRAME_ANY},
        '{STEP_CFG,  rfg_pkg::REG_PHASE_SUBTRACT,  32'd0,         1'b0, FRAME_ANY},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'hAAAA_AAAA, 1'b1, FRAME_EMIT},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'h5555_5555, 1'b1, FRAME_EMIT},
        '{STEP_TICK, rfg_pkg::REG_FRAME_DELAY,     32'h5555_5565, 1'b0, FRAME_NONE}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // one line per mismatch, output capped so a broken block cannot flood the log
    task automatic flag_fault(input string what);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS)
            $display("%0t ns  mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            flag_fault($sformatf("led %0d field %s: got %0d, expected %0d",
                                 leds_checked, name, got, want));
    endtask

    // packed colour word for a wheel position, components left unclipped
    function automatic logic [23:0] wheel_word(input logic [1:0] pal, input logic [7:0] pos);
        int unsigned q;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        r = 0;
        g = 0;
        b = 0;
        if (pal == rfg_pkg::PAL_FADE_OUT || pal == rfg_pkg::PAL_FADE_IN) begin
            q = (pal == rfg_pkg::PAL_FADE_OUT) ? pos : (255 - pos) & 8'hFF;
            if (q < 85) begin
                r = 3 * q;
                b = 3 * q;
            end else if (q < 170) begin
                q = (q + 85) & 8'hFF;
                g = 3 * q;
                b = 3 * q;
            end else begin
                q = (q + 170) & 8'hFF;
                r = 3 * q;
                g = 3 * q;
            end
        end else begin
            q = (255 - pos) & 8'hFF;
            if (q < 85) begin
                r = 255 - 3 * q;
                b = 3 * q;
            end else if (q < 170) begin
                q = q - 85;
                g = 3 * q;
                b = 255 - 3 * q;
            end else begin
                q = q - 170;
                r = 3 * q;
                g = 255 - 3 * q;
            end
        end
        return 24'((r << 16) | (g << 8) | b);
    endfunction

    // step the phase, decide on a frame and queue its led colours; returns 1 on a frame
    function automatic bit predict_tick(input rfg_pkg::t_tick item);
        logic [31:0]   elapsed;
        int unsigned   divisor;
        int unsigned   offset;
        logic [7:0]    pos;
        logic [23:0]   word;
        rfg_pkg::t_led led;
        wheel_phase = cfg_step_down ? wheel_phase - 8'd1 : wheel_phase + 8'd1;
        elapsed = item.now_ms - last_frame_ms;
        if (!item.transfer_idle || elapsed <= {16'd0, cfg_delay})
            return 1'b0;
        last_frame_ms = item.now_ms;
        // a zero delay divides as one
        divisor = (cfg_delay == 16'd0) ? 1 : cfg_delay;
        frame_count++;
        for (int r = 0; r < LED_ROWS; r++) begin
            for (int c = 0; c < LED_COLS; c++) begin
                offset = (c * 256) / divisor;
                pos = cfg_reverse ? 8'(offset - wheel_phase) : 8'(offset + wheel_phase);
                word = wheel_word(cfg_palette, pos);
                led.row       = 2'(r);
                led.column    = 4'(c);
                led.byte_low  = word[7:0];
                led.byte_mid  = word[15:8];
                led.byte_high = word[23:16];
                led.last      = (r == LED_ROWS - 1) && (c == LED_COLS - 1);
                pending_leds.push_back(led);
            end
        end
        return 1'b1;
    endfunction

    // register write, write enable dropped again before return so back-to-back writes never collide
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        unique case (idx)
            rfg_pkg::REG_FRAME_DELAY:     cfg_delay     = data;
            rfg_pkg::REG_PALETTE:         cfg_palette   = data[1:0];
            rfg_pkg::REG_PHASE_DECREMENT: cfg_step_down = data[0];
            rfg_pkg::REG_PHASE_SUBTRACT:  cfg_reverse   = data[0];
        endcase
        settings_written++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold off until every queued led has gone out and the core has settled
    task automatic wait_drain();
        @(posedge i_clk);
        while (pending_leds.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    // tick transfer with burst and gap shaping; valid stays up within a burst
    task automatic send_tick(input rfg_pkg::t_tick item, input t_frame_hint hint);
        bit framed;
        tick_if.valid   <= 1'b1;
        tick_if.payload <= item;
        @(posedge i_clk);
        while (!tick_if.ready)
            @(posedge i_clk);
        tick_count++;
        framed = predict_tick(item);
        if (hint != FRAME_ANY && framed != (hint == FRAME_EMIT))
            flag_fault($sformatf("tick %0d: frame decision disagrees with the script",
                                 tick_count));
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            tick_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 7);
        end
    endtask

    // led receiver: short stalls mixed with long ready stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            led_if.ready <= 1'b0;
            sink_hold    <= 0;
        end else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (led_if.ready) begin
            led_if.ready <= 1'b0;
            sink_hold    <= $urandom_range(0, 7);
        end else begin
            led_if.ready <= 1'b1;
            sink_hold    <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                        : $urandom_range(0, 5);
        end
    end

    // compare each led transfer with the oldest expected colour
    always @(posedge i_clk) begin
        rfg_pkg::t_led want;
        if (i_rst_n && led_if.valid && led_if.ready) begin
            if (pending_leds.size() == 0) begin
                flag_fault("led transfer with nothing expected");
            end else begin
                want = pending_leds.pop_front();
                check_field("row",       led_if.payload.row,       want.row);
                check_field("column",    led_if.payload.column,    want.column);
                check_field("byte_low",  led_if.payload.byte_low,  want.byte_low);
                check_field("byte_mid",  led_if.payload.byte_mid,  want.byte_mid);
                check_field("byte_high", led_if.payload.byte_high, want.byte_high);
                check_field("last",      led_if.payload.last,      want.last);
            end
            leds_checked++;
        end
    end

    // stimulus
    initial begin
        rfg_pkg::t_tick item;
        logic [31:0] clock_ms;
        logic [15:0] delay_pick;
        logic [1:0]  pal_pick;
        logic        down_pick;
        logic        rev_pick;
        int unsigned roll;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = rfg_pkg::REG_FRAME_DELAY;
        i_cfg_data      = '0;
        tick_if.valid   = 1'b0;
        tick_if.payload = '0;
        burst_left      = 0;
        fault_count     = 0;
        tick_count      = 0;
        frame_count     = 0;
        leds_checked    = 0;
        settings_written = 0;
        wheel_phase     = 8'd0;
        last_frame_ms   = 32'd0;
        cfg_delay       = rfg_pkg::FRAME_DELAY_RST;
        cfg_palette     = rfg_pkg::PAL_CLASSIC;
        cfg_step_down   = 1'b0;
        cfg_reverse     = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // scripted opening
        for (int n = 0; n < SCRIPT_ROWS; n++) begin
            if (script[n].kind == STEP_CFG) begin
                tick_if.valid <= 1'b0;
                wait_drain();
                write_reg(script[n].idx, script[n].value[15:0]);
            end else begin
                item.now_ms        = script[n].value;
                item.transfer_idle = script[n].idle;
                send_tick(item, script[n].hint);
            end
        end

        // random phases, each under its own register setting
        clock_ms = 32'h5555_5565;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            tick_if.valid <= 1'b0;
            wait_drain();
            unique case (p)
                0: begin
                    delay_pick = 16'd1;
                    pal_pick   = rfg_pkg::PAL_FADE_OUT;
                    down_pick  = 1'b1;
                    rev_pick   = 1'b0;
                end
                1: begin
                    delay_pick = 16'hFFFF;
                    pal_pick   = rfg_pkg::PAL_FADE_IN;
                    down_pick  = 1'b0;
                    rev_pick   = 1'b1;
                end
                2: begin
                    delay_pick = 16'd0;
                    pal_pick   = PAL_UNUSED;
                    down_pick  = 1'b1;
                    rev_pick   = 1'b1;
                end
                default: begin
                    roll = $urandom_range(0, 3);
                    if (roll == 0)
                        delay_pick = 16'($urandom_range(0, 3));
                    else if (roll == 1)
                        delay_pick = 16'($urandom_range(0, 65535));
                    else
                        delay_pick = 16'($urandom_range(5, 40));
                    pal_pick  = 2'($urandom_range(0, 3));
                    down_pick = 1'($urandom_range(0, 1));
                    rev_pick  = 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(rfg_pkg::REG_FRAME_DELAY, delay_pick);
            write_reg(rfg_pkg::REG_PALETTE, {14'd0, pal_pick});
            write_reg(rfg_pkg::REG_PHASE_DECREMENT, {15'd0, down_pick});
            write_reg(rfg_pkg::REG_PHASE_SUBTRACT, {15'd0, rev_pick});
            // now and then run the clock up to the 32-bit wrap
            if (p % 3 == 1)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);

            for (int k = 0; k < TICKS_PER_PHASE; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 6)
                    item.now_ms = $urandom;
                else if (roll < 10)
                    item.now_ms = clock_ms - $urandom_range(0, 64);
                else
                    item.now_ms = clock_ms + $urandom_range(0, 2 * cfg_delay + 2);
                clock_ms = item.now_ms;
                item.transfer_idle = ($urandom_range(0, 9) < 8);
                send_tick(item, FRAME_ANY);
            end
        end

        // let the last frames out, then watch for strays
        tick_if.valid <= 1'b0;
        wait_drain();
        repeat (100) @(posedge i_clk);

        $display("run covered %0d ticks across %0d register writes, %0d frames predicted",
                 tick_count, settings_written, frame_count);
        $display("%0d led transfers checked, %0d mismatches, %0d colours still owed",
                 leds_checked, fault_count, pending_leds.size());
        if (fault_count == 0 && pending_leds.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/rfg_pkg.sv
hdl/rfg_stream_if.sv
hdl/rainbow_frame_generator_core.sv
tb/sv/rainbow_frame_generator_core_test.sv
